// ----- rtl/core/spp_pkg.sv -----
// shared types, constants and helpers for the smooth arc path point block
package spp_pkg;

	localparam int DIV_STEPS = 16;
	localparam logic [16:0] Q16_ONE = 17'd65536;
	localparam logic [22:0] LIFT_RESET = 23'd209715;
	localparam int OUT_W = 24;

	localparam logic [1:0] REG_FIRST_LIFT  = 2'd0;
	localparam logic [1:0] REG_SECOND_LIFT = 2'd1;

	typedef enum logic [1:0] {
		PH_ZERO,
		PH_ONE,
		PH_DIV
	} phase_mode_t;

	typedef struct packed {
		logic signed [24:0] elapsed_time;
		logic [23:0]        segment_length;
		logic signed [23:0] start_x;
		logic signed [23:0] start_y;
		logic signed [23:0] start_z;
		logic signed [23:0] end_x;
		logic signed [23:0] end_y;
		logic signed [23:0] end_z;
		logic signed [23:0] start_wrist;
		logic signed [23:0] end_wrist;
	} item_t;

	typedef struct packed {
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic signed [23:0] point_z;
		logic signed [23:0] wrist_angle;
		logic [16:0]        phase;
	} result_t;

	// bezier weights in q32, all below 2^33
	typedef struct packed {
		logic [32:0] w0;
		logic [32:0] c1;
		logic [32:0] c2;
		logic [32:0] w3;
	} weights_t;

	function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
		logic signed [23:0] r;
		if (v > 40'sd8388607) begin
			r = 24'sd8388607;
		end else if (v < -40'sd8388608) begin
			r = -24'sd8388608;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/spp_div.sv -----
// pipelined restoring divider giving raw progress elapsed/length in q0.16
module spp_div (
	input  logic                clk,
	input  logic signed [24:0]  elapsed_time,
	input  logic [23:0]         segment_length,
	output logic [15:0]         ratio,
	output spp_pkg::phase_mode_t mode
);

	spp_pkg::phase_mode_t mode_in;
	logic [23:0] rem_q  [0:spp_pkg::DIV_STEPS];
	logic [23:0] len_q  [0:spp_pkg::DIV_STEPS];
	logic [15:0] quo_q  [0:spp_pkg::DIV_STEPS];
	spp_pkg::phase_mode_t mode_q [0:spp_pkg::DIV_STEPS];

	always_comb begin
		if (segment_length == 24'd0) begin
			mode_in = elapsed_time[24] ? spp_pkg::PH_ZERO : spp_pkg::PH_ONE;
		end else if (elapsed_time[24] || elapsed_time == 25'sd0) begin
			mode_in = spp_pkg::PH_ZERO;
		end else if (elapsed_time[23:0] >= segment_length) begin
			mode_in = spp_pkg::PH_ONE;
		end else begin
			mode_in = spp_pkg::PH_DIV;
		end
	end

	always_ff @(posedge clk) begin
		rem_q[0]  <= (mode_in == spp_pkg::PH_DIV) ? elapsed_time[23:0] : 24'd0;
		len_q[0]  <= segment_length;
		quo_q[0]  <= 16'd0;
		mode_q[0] <= mode_in;
	end

	for (genvar k = 0; k < spp_pkg::DIV_STEPS; k++) begin : g_step
		logic [24:0] dbl;
		logic [25:0] diff;
		always_comb begin
			dbl  = {rem_q[k], 1'b0};
			diff = {1'b0, dbl} - {2'b00, len_q[k]};
		end
		always_ff @(posedge clk) begin
			rem_q[k+1]  <= diff[25] ? dbl[23:0] : diff[23:0];
			quo_q[k+1]  <= {quo_q[k][14:0], ~diff[25]};
			len_q[k+1]  <= len_q[k];
			mode_q[k+1] <= mode_q[k];
		end
	end

	assign ratio = quo_q[spp_pkg::DIV_STEPS];
	assign mode  = mode_q[spp_pkg::DIV_STEPS];

endmodule

// ----- rtl/core/spp_lane.sv -----
// one coordinate lane: weighted bezier sum, lift, rounding and saturation
module spp_lane (
	input  logic               clk,
	input  spp_pkg::weights_t  weights,
	input  logic signed [23:0] p0,
	input  logic signed [23:0] p1,
	input  logic [22:0]        lift_a,
	input  logic [22:0]        lift_b,
	output logic signed [23:0] point
);

	logic signed [25:0] near_mix, far_mix;
	logic signed [59:0] m0_s1, m1_s1, m2_s1, m3_s1;
	logic [55:0]        la_s1, lb_s1;
	logic signed [60:0] sa_s2, sb_s2;
	logic [58:0]        sl_s2;
	logic signed [61:0] acc_s3;
	logic signed [61:0] rnd;

	// control point mixes 2*p0+p1 and p0+2*p1
	assign near_mix = $signed({p0[23], p0, 1'b0}) + $signed({{2{p1[23]}}, p1});
	assign far_mix  = $signed({{2{p0[23]}}, p0}) + $signed({p1[23], p1, 1'b0});
	assign rnd      = acc_s3 + 62'sd2147483648;

	always_ff @(posedge clk) begin
		m0_s1 <= $signed({1'b0, weights.w0}) * $signed({{2{p0[23]}}, p0});
		m1_s1 <= $signed({1'b0, weights.c1}) * near_mix;
		m2_s1 <= $signed({1'b0, weights.c2}) * far_mix;
		m3_s1 <= $signed({1'b0, weights.w3}) * $signed({{2{p1[23]}}, p1});
		la_s1 <= weights.c1 * lift_a;
		lb_s1 <= weights.c2 * lift_b;

		sa_s2 <= {m0_s1[59], m0_s1} + {m1_s1[59], m1_s1};
		sb_s2 <= {m2_s1[59], m2_s1} + {m3_s1[59], m3_s1};
		sl_s2 <= {2'b00, la_s1, 1'b0} + {3'b000, la_s1}
			+ {2'b00, lb_s1, 1'b0} + {3'b000, lb_s1};

		acc_s3 <= {sa_s2[60], sa_s2} + {sb_s2[60], sb_s2} + $signed({3'b000, sl_s2});

		point <= spp_pkg::sat24({{10{rnd[61]}}, rnd[61:32]});
	end

endmodule

// ----- rtl/core/smooth_arc_path_point_top.sv -----
// smooth arc path point: top level with timing shaper, weights, lanes and merge
//
// channel  | handshake          | payload
// item     | start, busy        | item (spp_pkg::item_t)
// result   | done (one cycle)   | result (spp_pkg::result_t)
// config   | cfg_valid/ready    | cfg_index, cfg_data
//
// one item per clock, fully pipelined; each item passes through the 16-step divider,
// the weight multipliers and the lanes before its result is on the ports.
// busy stays low, so the block never stalls; the receiver cannot stall either.
// reset clears the valid pipe and restores both lift registers.
module smooth_arc_path_point_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  spp_pkg::item_t    item,
	output logic              done,
	output spp_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [22:0]       cfg_data
);

	localparam int P_DIV   = spp_pkg::DIV_STEPS;
	localparam int P_S3    = P_DIV + 3;
	localparam int P_S4    = P_DIV + 4;
	localparam int P_S5    = P_DIV + 5;
	localparam int P_LAST  = P_DIV + 9;
	localparam int TAIL_D  = P_LAST - P_S5;
	localparam int LATENCY = P_LAST + 2;

	typedef struct packed {
		logic signed [23:0] wrist;
		logic [16:0]        phase;
	} tail_t;

	logic        accept;
	logic [22:0] first_lift_q, second_lift_q;
	logic        valid_q [0:P_LAST];
	spp_pkg::item_t item_q [0:P_LAST];

	logic [15:0] ratio;
	spp_pkg::phase_mode_t mode_div, mode_s1, mode_s2;
	logic [15:0] ratio_s1;
	logic [31:0] sq_s1;
	logic [49:0] num_s2, num_rnd;
	logic [16:0] s_s3, s_s4, u_s4, u;
	logic [33:0] u2_s4, s2_s4;
	logic signed [24:0] wdiff;
	logic signed [42:0] wprod_s4, wprod_rnd;
	logic [50:0] t_w0, t_c1, t_c2, t_w3;
	spp_pkg::weights_t weights_s5;
	tail_t tail_s5;
	tail_t tail_q [1:TAIL_D];
	logic signed [23:0] lane_x, lane_y, lane_z;
	spp_pkg::item_t last;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_lift_q  <= spp_pkg::LIFT_RESET;
			second_lift_q <= spp_pkg::LIFT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				spp_pkg::REG_FIRST_LIFT:  first_lift_q  <= cfg_data;
				spp_pkg::REG_SECOND_LIFT: second_lift_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid and item travel alongside every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= P_LAST; k++) valid_q[k] <= 1'b0;
			done <= 1'b0;
		end else begin
			valid_q[0] <= accept;
			for (int k = 1; k <= P_LAST; k++) valid_q[k] <= valid_q[k-1];
			done <= valid_q[P_LAST];
		end
	end

	always_ff @(posedge clk) begin
		item_q[0] <= item;
		for (int k = 1; k <= P_LAST; k++) item_q[k] <= item_q[k-1];
	end

	spp_div u_div (
		.clk            (clk),
		.elapsed_time   (item.elapsed_time),
		.segment_length (item.segment_length),
		.ratio          (ratio),
		.mode           (mode_div)
	);

	always_comb begin
		num_rnd   = num_s2 + 50'd2147483648;
		u         = spp_pkg::Q16_ONE - s_s3;
		wdiff     = $signed({item_q[P_S3].end_wrist[23], item_q[P_S3].end_wrist})
			- $signed({item_q[P_S3].start_wrist[23], item_q[P_S3].start_wrist});
		t_w0      = u2_s4 * u_s4;
		t_c1      = u2_s4 * s_s4;
		t_c2      = s2_s4 * u_s4;
		t_w3      = s2_s4 * s_s4;
		wprod_rnd = wprod_s4 + 43'sd32768;
	end

	always_ff @(posedge clk) begin
		// smoothstep 3r^2 - 2r^3
		sq_s1    <= ratio * ratio;
		ratio_s1 <= ratio;
		mode_s1  <= mode_div;
		num_s2   <= sq_s1 * (18'd196608 - {1'b0, ratio_s1, 1'b0});
		mode_s2  <= mode_s1;
		case (mode_s2)
			spp_pkg::PH_ZERO: s_s3 <= 17'd0;
			spp_pkg::PH_ONE:  s_s3 <= spp_pkg::Q16_ONE;
			default:          s_s3 <= num_rnd[48:32];
		endcase

		s_s4     <= s_s3;
		u_s4     <= u;
		u2_s4    <= u * u;
		s2_s4    <= s_s3 * s_s3;
		wprod_s4 <= $signed({1'b0, s_s3}) * wdiff;

		weights_s5.w0 <= t_w0[48:16];
		weights_s5.c1 <= t_c1[48:16];
		weights_s5.c2 <= t_c2[48:16];
		weights_s5.w3 <= t_w3[48:16];
		tail_s5.phase <= s_s4;
		tail_s5.wrist <= spp_pkg::sat24(
			{{16{item_q[P_S4].start_wrist[23]}}, item_q[P_S4].start_wrist}
			+ {{13{wprod_rnd[42]}}, wprod_rnd[42:16]});

		tail_q[1] <= tail_s5;
		for (int k = 2; k <= TAIL_D; k++) tail_q[k] <= tail_q[k-1];
	end

	spp_lane u_lane_x (
		.clk (clk), .weights (weights_s5),
		.p0 (item_q[P_S5].start_x), .p1 (item_q[P_S5].end_x),
		.lift_a (23'd0), .lift_b (23'd0), .point (lane_x)
	);

	spp_lane u_lane_y (
		.clk (clk), .weights (weights_s5),
		.p0 (item_q[P_S5].start_y), .p1 (item_q[P_S5].end_y),
		.lift_a (23'd0), .lift_b (23'd0), .point (lane_y)
	);

	spp_lane u_lane_z (
		.clk (clk), .weights (weights_s5),
		.p0 (item_q[P_S5].start_z), .p1 (item_q[P_S5].end_z),
		.lift_a (first_lift_q), .lift_b (second_lift_q), .point (lane_z)
	);

	assign last = item_q[P_LAST];

	// merge: a segment with no travel keeps its start point
	always_ff @(posedge clk) begin
		if (last.start_x == last.end_x && last.start_y == last.end_y
			&& last.start_z == last.end_z) begin
			result.point_x <= last.start_x;
			result.point_y <= last.start_y;
			result.point_z <= last.start_z;
		end else begin
			result.point_x <= lane_x;
			result.point_y <= lane_y;
			result.point_z <= lane_z;
		end
		result.wrist_angle <= tail_q[TAIL_D].wrist;
		result.phase       <= tail_q[TAIL_D].phase;
	end

`ifndef SYNTHESIS
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.phase <= spp_pkg::Q16_ONE)
		else $error("phase above one");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("transfer produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a transfer");
`endif

endmodule
